/* design/b92_pkg.sv */
// Shared constants, types and helper functions of the base-92 chunk decoder.
`default_nettype none

package b92_pkg;

	localparam int CODE_W    = 8;
	localparam int LEN_W     = 13;
	localparam int DIGIT_W   = 7;
	localparam int ACC_W     = 32;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 3;
	localparam int CNT_W     = 3;
	localparam int GROUP_BYTES = 4;
	localparam int RADIX     = 92;
	localparam int MAX_ENCODED_LEN = 8191;

	// Longest message taken; a longer length field is clipped to it.
	localparam logic [LEN_W-1:0] LEN_CAP = (MAX_ENCODED_LEN >= (2**LEN_W - 1)) ?
		{LEN_W{1'b1}} : LEN_W'(MAX_ENCODED_LEN);

	localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
	localparam logic [POS_W-1:0] POS_PAIR  = 3'd1;
	localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

	localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
	localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
	localparam logic [CNT_W-1:0] CNT_GROUP = 3'd4;

	// Result of one character handed from the group unit to the byte drain.
	typedef struct packed {
		logic [CNT_W-1:0]                   n;
		logic                               last;
		logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes;
	} grp_res_t;

	// Map an encoded character onto its digit; unknown codes give zero.
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CODE_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		case (c) inside
			[8'h61:8'h7A]: d = DIGIT_W'(c - 8'h61);          // a..z
			[8'h41:8'h5A]: d = DIGIT_W'(c - 8'h41 + 8'd26);  // A..Z
			[8'h30:8'h39]: d = DIGIT_W'(c - 8'h30 + 8'd52);  // 0..9
			8'h21: d = 7'd62;  // !
			8'h24: d = 7'd63;  // $
			8'h25: d = 7'd64;  // %
			8'h5E: d = 7'd65;  // ^
			8'h26: d = 7'd66;  // &
			8'h2A: d = 7'd67;  // *
			8'h2D: d = 7'd68;  // -
			8'h5F: d = 7'd69;  // _
			8'h3D: d = 7'd70;  // =
			8'h2B: d = 7'd71;  // +
			8'h28: d = 7'd72;  // (
			8'h29: d = 7'd73;  // )
			8'h5B: d = 7'd74;  // [
			8'h5D: d = 7'd75;  // ]
			8'h7B: d = 7'd76;  // {
			8'h7D: d = 7'd77;  // }
			8'h3C: d = 7'd78;  // <
			8'h3E: d = 7'd79;  // >
			8'h27: d = 7'd80;  // '
			8'h40: d = 7'd81;  // @
			8'h23: d = 7'd82;  // #
			8'h7E: d = 7'd83;  // ~
			8'h3B: d = 7'd84;  // ;
			8'h3A: d = 7'd85;  // :
			8'h2F: d = 7'd86;  // /
			8'h3F: d = 7'd87;  // ?
			8'h2C: d = 7'd88;  // ,
			8'h2E: d = 7'd89;  // .
			8'h7C: d = 7'd90;  // |
			8'h5C: d = 7'd91;  // backslash
			default: d = '0;
		endcase
		return d;
	endfunction

	// Place value of a digit within its group: 92 to the power of pos.
	function automatic logic [ACC_W-1:0] weight_of(input logic [POS_W-1:0] pos);
		logic [ACC_W-1:0] w;
		case (pos)
			3'd0:    w = 32'd1;
			3'd1:    w = 32'd92;
			3'd2:    w = 32'd8464;
			3'd3:    w = 32'd778688;
			default: w = 32'd71639296;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* design/b92_in_if.sv */
// Input channel: one encoded character per beat.
`default_nettype none

interface b92_in_if import b92_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;
	logic              first;
	logic [LEN_W-1:0]  total_len;

	modport source(output valid, code, first, total_len, input ready);
	modport sink(input valid, code, first, total_len, output ready);
endinterface

`default_nettype wire

/* design/b92_out_if.sv */
// Output channel: one decoded byte per beat.
`default_nettype none

interface b92_out_if import b92_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last;

	modport source(output valid, data_byte, last, input ready);
	modport sink(input valid, data_byte, last, output ready);
endinterface

`default_nettype wire

/* design/base92_chunk_decoder_core.sv */
// Top level of the base-92 chunk decoder.
//
// in_ch carries one encoded character per beat; first marks the opening
// character of a message and total_len, read with it, gives the number of
// characters. out_ch carries decoded bytes, least significant byte of a
// group first, with last set on the final byte of the message.
// A beat is taken into an input register; from there the group unit folds
// its digit into the running group value (one 7x32 multiply and add) and,
// when a group or a pair closes, loads the byte buffer that drives out_ch.
// Throughput is one character per cycle while in_ch.ready stays high. A
// five-character group yields four bytes that drain at one per cycle while
// out_ch.ready is high, in step with the next group. A single byte (second
// of a pair, or a lone final character) that completes while a group still
// drains holds the input register, so in_ch.ready drops until the buffer
// can take it. When the receiver stalls, the buffer holds its byte and the
// input register fills, then ready drops.
// Reset clears the message state and empties the input register and byte buffer;
// a character that is not first while no message is open is dropped.
`default_nettype none

module base92_chunk_decoder_core import b92_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	b92_in_if.sink    in_ch,
	b92_out_if.source out_ch
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              first_s1;
	logic [LEN_W-1:0]  total_len_s1;
	logic              take, commit, can_load;
	grp_res_t          res;

	// Commit the held character once its bytes, if any, fit the buffer.
	assign commit      = valid_s1 && ((res.n == CNT_NONE) || can_load);
	assign in_ch.ready = !valid_s1 || commit;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_s1      <= in_ch.code;
			first_s1     <= in_ch.first;
			total_len_s1 <= in_ch.total_len;
		end
	end

	b92_group_unit u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.code      (code_s1),
		.first     (first_s1),
		.total_len (total_len_s1),
		.res       (res)
	);

	b92_byte_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (commit && (res.n != CNT_NONE)),
		.res       (res),
		.out_ready (out_ch.ready),
		.can_load  (can_load),
		.out_valid (out_ch.valid),
		.data_byte (out_ch.data_byte),
		.last      (out_ch.last)
	);

endmodule

`default_nettype wire

/* design/b92_group_unit.sv */
// Group state and single-pass digit accumulation for one character.
`default_nettype none

module b92_group_unit import b92_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              commit,
	input  wire logic [CODE_W-1:0] code,
	input  wire logic              first,
	input  wire logic [LEN_W-1:0]  total_len,
	output grp_res_t               res
);

	logic [LEN_W-1:0] chars_left_q, cl_eff, cl_dec, cl_d, len_clip;
	logic [POS_W-1:0] group_pos_q, gp_eff, gp_d, pos_w;
	logic             wide_q, wide_eff, wide_now, wide_d;
	logic [ACC_W-1:0] accum_q, acc_eff, acc_base, acc_d, prod, sum;
	logic [DIGIT_W-1:0] d;
	logic             start;

	always_comb begin
		len_clip = (total_len > LEN_CAP) ? LEN_CAP : total_len;
		cl_eff   = first ? len_clip : chars_left_q;
		gp_eff   = first ? POS_FIRST : group_pos_q;
		wide_eff = first ? 1'b0 : wide_q;
		acc_eff  = first ? '0 : accum_q;
		start    = (gp_eff == POS_FIRST);
		wide_now = start ? ((cl_eff > LEN_W'(6)) || (cl_eff == LEN_W'(5))) : wide_eff;
		acc_base = start ? '0 : acc_eff;
		d        = digit_of(code);
		if (wide_now) begin
			pos_w = (gp_eff > POS_LAST) ? POS_LAST : gp_eff;
		end else begin
			pos_w = start ? POS_FIRST : POS_PAIR;
		end
		prod   = {{(ACC_W-DIGIT_W){1'b0}}, d} * weight_of(pos_w);
		sum    = acc_base + prod;
		cl_dec = cl_eff - LEN_W'(1);

		cl_d      = cl_eff;
		gp_d      = gp_eff;
		wide_d    = wide_eff;
		acc_d     = acc_eff;
		res.n     = CNT_NONE;
		res.last  = 1'b0;
		res.bytes = sum;

		if (cl_eff != '0) begin
			cl_d   = cl_dec;
			wide_d = wide_now;
			if (wide_now) begin
				if (gp_eff >= POS_LAST) begin
					res.n    = CNT_GROUP;
					res.last = (cl_dec == '0);
					gp_d     = POS_FIRST;
					acc_d    = '0;
				end else begin
					gp_d  = gp_eff + POS_W'(1);
					acc_d = sum;
				end
			end else if (start && cl_dec != '0) begin
				gp_d  = POS_PAIR;
				acc_d = sum;
			end else begin
				// second digit of a pair, or a lone final character
				res.n    = CNT_ONE;
				res.last = (cl_dec == '0);
				gp_d     = POS_FIRST;
				acc_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_left_q <= '0;
			group_pos_q  <= POS_FIRST;
			wide_q       <= 1'b0;
			accum_q      <= '0;
		end else if (commit) begin
			chars_left_q <= cl_d;
			group_pos_q  <= gp_d;
			wide_q       <= wide_d;
			accum_q      <= acc_d;
		end
	end

endmodule

`default_nettype wire

/* design/b92_byte_drain.sv */
// Output buffer that holds one result and hands its bytes out one per beat.
`default_nettype none

module b92_byte_drain import b92_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire grp_res_t          res,
	input  wire logic              out_ready,
	output logic                   can_load,
	output logic                   out_valid,
	output logic [BYTE_W-1:0]      data_byte,
	output logic                   last
);

	logic [CNT_W-1:0]                   cnt_q;
	logic [GROUP_BYTES-1:0][BYTE_W-1:0] bytes_q;
	logic                               last_q;
	logic                               pop;

	assign out_valid = (cnt_q != CNT_NONE);
	assign pop       = out_valid && out_ready;
	assign can_load  = (cnt_q == CNT_NONE) || ((cnt_q == CNT_ONE) && out_ready);
	assign data_byte = bytes_q[0];
	assign last      = last_q && (cnt_q == CNT_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_NONE;
		end else if (load) begin
			cnt_q <= res.n;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
		end else if (pop) begin
			// advance the next byte to the head
			for (int i = 0; i < GROUP_BYTES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

/* design/b92_checker.sv */
// Port-level checks of the decoder, bound to the top level.
`default_nettype none

module b92_checker import b92_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              in_first,
	input wire logic [LEN_W-1:0]  in_total_len,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [BYTE_W-1:0] out_data_byte,
	input wire logic              out_last
);

	// A stalled byte holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data_byte) && $stable(out_last))
		else $error("output beat changed while stalled");

	// With the byte buffer empty the input side is never blocked.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// A one-character message reaches an idle output through the input register and the byte buffer, marked last.
	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_first && in_total_len == LEN_W'(1)) ##1 !out_valid
		|=> out_valid && out_last)
		else $error("single-character message not delivered as last byte");

endmodule

bind base92_chunk_decoder_core b92_checker u_b92_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.in_first      (in_ch.first),
	.in_total_len  (in_ch.total_len),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_data_byte (out_ch.data_byte),
	.out_last      (out_ch.last)
);

`default_nettype wire
